@@ sv/slos_pkg.sv @@
// ----------------------------------------------------------------------------
// slos_pkg: shared definitions for the skew line occupancy score block
// Geometry limits, field widths, codes and the control structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slos_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

    localparam int X_BITS    = $clog2(MAX_WIDTH);
    localparam int Y_BITS    = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS = $clog2(MAP_DEPTH);

    localparam int GEOM_BITS  = 11;
    localparam int GRAY_BITS  = 8;
    localparam int COORD_BITS = 10;
    localparam int TILT_BITS  = 11;
    localparam int COUNT_BITS = 11;
    localparam int ERR_BITS   = GEOM_BITS + 2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK_THRESHOLD = 2'd2;

    localparam logic [GEOM_BITS-1:0] WIDTH_RESET     = 11'd1024;
    localparam logic [GEOM_BITS-1:0] HEIGHT_RESET    = 11'd1024;
    localparam logic [GRAY_BITS-1:0] THRESHOLD_RESET = 8'd128;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SCORE = 1'b1;

    typedef struct packed {
        logic wr_pixel;
        logic start;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic geom_empty;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/slos_in_if.sv @@
// ----------------------------------------------------------------------------
// slos_in_if: input word channel
// Valid/ready handshake carrying one load or score request.
// ----------------------------------------------------------------------------
`default_nettype none

interface slos_in_if;
    import slos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [GRAY_BITS-1:0]  gray_level;
    logic signed [TILT_BITS-1:0] tilt;

    modport source (output valid, func, pixel_x, pixel_y, gray_level, tilt,
                    input ready);
    modport sink   (input valid, func, pixel_x, pixel_y, gray_level, tilt,
                    output ready);
endinterface

`default_nettype wire

@@ sv/slos_out_if.sv @@
// ----------------------------------------------------------------------------
// slos_out_if: result word channel
// Valid/ready handshake carrying one occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

interface slos_out_if;
    import slos_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] occupied_lines;

    modport source (output valid, occupied_lines, input ready);
    modport sink   (input valid, occupied_lines, output ready);
endinterface

`default_nettype wire

@@ sv/slos_ctrl.sv @@
// ----------------------------------------------------------------------------
// slos_ctrl: sequencer for loads and score scans
// Accepts words, starts a scan, waits for the read pipeline to drain and
// hands the count to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slos_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_func,
    output logic                     o_in_ready,
    input  wire slos_pkg::t_dp_status i_status,
    output slos_pkg::t_dp_cmd        o_cmd
);
    import slos_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_SCORE) begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.geom_empty ? ST_FINISH : ST_SCAN;
                    end else begin
                        o_cmd.wr_pixel = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire

@@ sv/slos_datapath.sv @@
// ----------------------------------------------------------------------------
// slos_datapath: bit map, line walker and counters
// Holds the configuration, the black pixel map, the Bresenham walker that
// reads one pixel per cycle, the hit/count logic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slos_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire slos_pkg::t_dp_cmd                    i_cmd,
    output slos_pkg::t_dp_status                      o_status,
    input  wire logic                                 i_cfg_we,
    input  wire logic [slos_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [slos_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic [slos_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  wire logic [slos_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  wire logic [slos_pkg::GRAY_BITS-1:0]       i_gray_level,
    input  wire logic signed [slos_pkg::TILT_BITS-1:0] i_tilt,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [slos_pkg::COUNT_BITS-1:0]           o_occupied_lines
);
    import slos_pkg::*;

    // Configuration.
    logic [GEOM_BITS-1:0] r_cfg_width;
    logic [GEOM_BITS-1:0] r_cfg_height;
    logic [GRAY_BITS-1:0] r_cfg_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_cfg_thr    <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:     r_cfg_width  <= i_cfg_data[GEOM_BITS-1:0];
                CFG_IMAGE_HEIGHT:    r_cfg_height <= i_cfg_data[GEOM_BITS-1:0];
                CFG_BLACK_THRESHOLD: r_cfg_thr    <= i_cfg_data[GRAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Saturated geometry and clamped tilt magnitude, taken at scan start.
    logic [GEOM_BITS-1:0] w_sat;
    logic [GEOM_BITS-1:0] h_sat;
    logic [GEOM_BITS-1:0] h_sat_m1;
    logic [GEOM_BITS-1:0] lim;
    logic [GEOM_BITS-1:0] mag_raw;
    logic [GEOM_BITS-1:0] mag_clamp;

    always_comb begin
        w_sat     = (32'(r_cfg_width) > MAX_WIDTH) ? GEOM_BITS'(MAX_WIDTH) : r_cfg_width;
        h_sat     = (32'(r_cfg_height) > MAX_HEIGHT) ? GEOM_BITS'(MAX_HEIGHT)
                                                     : r_cfg_height;
        h_sat_m1  = h_sat - GEOM_BITS'(1);
        lim       = (w_sat < h_sat_m1) ? w_sat : h_sat_m1;
        mag_raw   = i_tilt[TILT_BITS-1] ? GEOM_BITS'(-i_tilt) : GEOM_BITS'(i_tilt);
        mag_clamp = (mag_raw > lim) ? lim : mag_raw;
    end

    // Scan state.
    logic [GEOM_BITS-1:0] r_w;
    logic [X_BITS-1:0]    r_w_m1;
    logic [Y_BITS-1:0]    r_h_m1;
    logic [GEOM_BITS-1:0] r_mag;
    logic                 r_dir_pos;
    logic                 r_dir_neg;
    logic [X_BITS-1:0]    r_x;
    logic [Y_BITS-1:0]    r_y;
    logic [Y_BITS-1:0]    r_y0;
    logic signed [ERR_BITS-1:0] r_err;

    logic signed [ERR_BITS-1:0] n_err_sum;
    logic                       row_step;
    logic [Y_BITS-1:0]          y_up;
    logic [Y_BITS-1:0]          y_dn;
    logic                       line_end;

    always_comb begin
        n_err_sum = r_err + $signed({2'b00, r_mag});
        row_step  = ($signed({n_err_sum, 1'b0}) >= $signed({3'b000, r_w}));
        y_up      = (r_y == r_h_m1) ? '0 : r_y + Y_BITS'(1);
        y_dn      = (r_y == '0) ? r_h_m1 : r_y - Y_BITS'(1);
        line_end  = (r_x == r_w_m1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_w       <= w_sat;
            r_w_m1    <= X_BITS'(w_sat - GEOM_BITS'(1));
            r_h_m1    <= Y_BITS'(h_sat_m1);
            r_mag     <= mag_clamp;
            r_dir_pos <= !i_tilt[TILT_BITS-1] && (i_tilt != '0);
            r_dir_neg <= i_tilt[TILT_BITS-1];
            r_x       <= '0;
            r_y       <= '0;
            r_y0      <= '0;
            r_err     <= '0;
        end else if (i_cmd.step) begin
            if (line_end) begin
                r_x   <= '0;
                r_y0  <= r_y0 + Y_BITS'(1);
                r_y   <= r_y0 + Y_BITS'(1);
                r_err <= '0;
            end else begin
                r_x <= r_x + X_BITS'(1);
                if (row_step) begin
                    r_err <= n_err_sum - $signed({2'b00, r_w});
                    if (r_dir_pos) begin
                        r_y <= y_up;
                    end else if (r_dir_neg) begin
                        r_y <= y_dn;
                    end
                end else begin
                    r_err <= n_err_sum;
                end
            end
        end
    end

    // Black pixel map: one write port for loads, one registered read port for scans.
    logic                 r_map [MAP_DEPTH];
    logic                 r_rd;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_in_range;

    always_comb begin
        wr_addr     = ADDR_BITS'(32'(i_pixel_y) * MAX_WIDTH + 32'(i_pixel_x));
        rd_addr     = ADDR_BITS'(32'(r_y) * MAX_WIDTH + 32'(r_x));
        wr_in_range = (32'(i_pixel_x) < MAX_WIDTH) && (32'(i_pixel_y) < MAX_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pixel && wr_in_range) begin
            r_map[wr_addr] <= (i_gray_level < r_cfg_thr);
        end
        if (i_cmd.step) begin
            r_rd <= r_map[rd_addr];
        end
    end

    // Hit and count stage, in the cycle after the read.
    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic                  r_hit;
    logic [COUNT_BITS-1:0] r_count;
    logic                  hit_now;

    assign hit_now = r_hit | r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_s1_last <= line_end;
        end
        if (i_cmd.start) begin
            r_hit   <= 1'b0;
            r_count <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_count <= r_count + COUNT_BITS'(hit_now);
                r_hit   <= 1'b0;
            end else begin
                r_hit <= hit_now;
            end
        end
    end

    // Output register.
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_occupied_lines = r_out_data;

    always_comb begin
        o_status.geom_empty = (w_sat == '0) || (h_sat == '0);
        o_status.last_issue = line_end && (r_y0 == r_h_m1);
        o_status.pipe_busy  = r_s1_valid;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end
endmodule

`default_nettype wire

@@ sv/skew_line_occupancy_score_top.sv @@
// ----------------------------------------------------------------------------
// skew_line_occupancy_score_top: tilted line occupancy score over a bit map
// Loads threshold gray pixels into a black bit map; score requests count the
// start rows whose wrapping Bresenham line across the image meets black.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word contents
//  i_in      in         valid/ready          func, pixel_x, pixel_y, gray_level, tilt
//  o_out     out        valid/ready          occupied_lines
//  i_cfg_*   in         write enable only    register index, write data
//
// A load word writes the bit map and the block is ready again in the next cycle.
// A score word reads width*height map pixels, one pixel per cycle through
// the single read port of the bit map, then drains the read pipeline and hands
// the count to the output register, which shows it on o_out; with zero width
// or height the scan and the drain are skipped.
// While a scan runs, i_in.ready is low. A count waiting in the output register
// does not block loads; a later scan holds its count until the register frees.
// Reset is synchronous and active low; the bit map is not cleared, so each
// pixel that a scan touches must have been loaded first.
`default_nettype none

module skew_line_occupancy_score_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    slos_in_if.sink                                 i_in,
    slos_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [slos_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [slos_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import slos_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns the input handshake and sequencing.
    slos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the map, the walker, the counters and the result word.
    slos_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_x        (i_in.pixel_x),
        .i_pixel_y        (i_in.pixel_y),
        .i_gray_level     (i_in.gray_level),
        .i_tilt           (i_in.tilt),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_occupied_lines (o_out.occupied_lines)
    );
endmodule

`default_nettype wire

@@ tb/tb_skew_line_occupancy_score_top.sv @@
// ----------------------------------------------------------------------------
// tb_skew_line_occupancy_score_top: self-checking bench for the skew score
// Loads gray pixels and sends score requests through the valid/ready input
// channel. A bit-map shadow in the bench predicts each occupancy count not typed in the table.
// Counts that come back are compared in order. A directed table comes first,
// then random phases, each with its own geometry and threshold.
// ----------------------------------------------------------------------------
module tb_skew_line_occupancy_score_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slos_pkg::*;

    // Kinds of rows in the directed table. The meaning of the three
    // arguments depends on the kind:
    //   ROW_CFG   a = register index, b = write data
    //   ROW_FILL  a = gray level written to every pixel of the image area
    //   ROW_LOAD  a = x, b = y, c = gray level
    //   ROW_SCORE a = tilt
    typedef enum logic [1:0] {ROW_CFG, ROW_FILL, ROW_LOAD, ROW_SCORE} t_row_kind;

    typedef struct {
        t_row_kind kind;
        int        a;
        int        b;
        int        c;
        bit        has_count;
        int        count;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    slos_in_if  in_if ();
    slos_out_if out_if ();

    skew_line_occupancy_score_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the bit map. The seen flags track which pixels have been
    // loaded, so that no scan ever touches a pixel that was never written.
    bit pix_black [MAP_DEPTH];
    bit pix_seen  [MAP_DEPTH];

    // Shadow of the configuration registers, as written.
    int geom_w;
    int geom_h;
    int thr_level;

    // Occupancy counts still owed by the block, oldest first.
    logic [COUNT_BITS-1:0] pending_counts [$];
    logic [COUNT_BITS-1:0] want_count;
    int mismatches;

    // Sender burst state and receiver stall pattern.
    int burst_left;
    int sink_mode;
    int sink_left;

    // Counts the start rows whose wrapping Bresenham line meets a black pixel.
    function automatic logic [COUNT_BITS-1:0] count_occupied(
        input logic signed [TILT_BITS-1:0] tilt);
        int w, h, t, dir, mag, lim, row, err, n, y0, x;
        bit hit;
        w = (geom_w > MAX_WIDTH) ? MAX_WIDTH : geom_w;
        h = (geom_h > MAX_HEIGHT) ? MAX_HEIGHT : geom_h;
        if (w == 0 || h == 0) begin
            return '0;
        end
        t   = tilt;
        dir = (t > 0) ? 1 : ((t < 0) ? -1 : 0);
        mag = (t < 0) ? -t : t;
        lim = (w < h - 1) ? w : h - 1;
        if (mag > lim) begin
            mag = lim;
        end
        n = 0;
        for (y0 = 0; y0 < h; y0++) begin
            row = y0;
            err = 0;
            hit = 1'b0;
            for (x = 0; x < w; x++) begin
                if (pix_black[row * MAX_WIDTH + x]) begin
                    hit = 1'b1;
                end
                err += mag;
                if (2 * err >= w) begin
                    if (dir > 0) begin
                        row = (row + 1 >= h) ? 0 : row + 1;
                    end else if (dir < 0) begin
                        row = (row == 0) ? h - 1 : row - 1;
                    end
                    err -= w;
                end
            end
            if (hit) begin
                n++;
            end
        end
        return COUNT_BITS'(n);
    endfunction

    // Tilts: small drifts, zero, some anywhere in range, some at the ends.
    function automatic int pick_tilt();
        case ($urandom_range(0, 5))
            0:       return -1023;
            1:       return 1023;
            2:       return 0;
            3:       return int'($urandom_range(0, 2046)) - 1023;
            default: return int'($urandom_range(0, 20)) - 10;
        endcase
    endfunction

    // Gray levels around the threshold are the interesting ones.
    function automatic int pick_gray();
        case ($urandom_range(0, 3))
            0:       return (thr_level == 0) ? 0 : thr_level - 1;
            1:       return (thr_level > 255) ? 255 : thr_level;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Offers one word and returns once it has been accepted. Fields that the
    // operation ignores carry random values.
    task automatic send_word(input logic func, input int x, input int y,
                             input int gray, input int tilt,
                             input bit has_count, input int count);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        if (func == FUNC_LOAD) begin
            tilt = int'($urandom_range(0, 2046)) - 1023;
        end else begin
            x    = $urandom_range(0, MAX_WIDTH - 1);
            y    = $urandom_range(0, MAX_HEIGHT - 1);
            gray = $urandom_range(0, 255);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= func;
        in_if.pixel_x    <= COORD_BITS'(x);
        in_if.pixel_y    <= COORD_BITS'(y);
        in_if.gray_level <= GRAY_BITS'(gray);
        in_if.tilt       <= TILT_BITS'(tilt);
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        // The word is in: update the shadow map or record the owed count.
        if (func == FUNC_LOAD) begin
            pix_black[y * MAX_WIDTH + x] = (gray < thr_level);
            pix_seen[y * MAX_WIDTH + x]  = 1'b1;
        end else if (has_count) begin
            pending_counts.push_back(COUNT_BITS'(count));
        end else begin
            pending_counts.push_back(count_occupied(TILT_BITS'(tilt)));
        end
    endtask

    // Registers change only while the block is idle: every owed count has
    // come back and a load has had time to settle.
    task automatic write_reg(input int idx, input int value);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_BITS'(idx);
        i_cfg_data <= CFG_DATA_BITS'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            geom_w = value & 'h7FF;
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            geom_h = value & 'h7FF;
        end else if (idx == CFG_BLACK_THRESHOLD) begin
            thr_level = value & 'hFF;
        end
    endtask

    // Loads the configured image area. With redo clear, only pixels never
    // loaded before are written; a negative gray asks for random levels.
    task automatic fill_area(input int gray, input bit redo);
        int w, h;
        w = (geom_w > MAX_WIDTH) ? MAX_WIDTH : geom_w;
        h = (geom_h > MAX_HEIGHT) ? MAX_HEIGHT : geom_h;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if (redo || !pix_seen[y * MAX_WIDTH + x]) begin
                    send_word(FUNC_LOAD, x, y,
                              (gray < 0) ? int'($urandom_range(0, 255)) : gray,
                              0, 1'b0, 0);
                end
            end
        end
    endtask

    // Receiver: switches between stretches of steady acceptance, coin-flip
    // stalls and mostly-stalled stretches.
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 2);
            sink_left = $urandom_range(5, 40);
        end
        sink_left--;
        case (sink_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            default: out_if.ready <= (sink_left % 7 == 0);
        endcase
    end

    // Every accepted count is matched against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: count %0d arrived with none owed", $time,
                         out_if.occupied_lines);
                mismatches++;
            end else begin
                want_count = pending_counts.pop_front();
                if (out_if.occupied_lines !== want_count) begin
                    $display("%0t: occupied_lines expected %0d, actual %0d", $time,
                             want_count, out_if.occupied_lines);
                    mismatches++;
                end
            end
        end
    end

    // Directed table. The first rows rely on the reset height of 1024 and
    // the reset threshold of 128. Rows with a typed count are obvious from
    // the setup; the others go through the predictor.
    t_plan_row plan [$] = '{
        // Width 1 over the full reset height: one pixel per line, and the
        // tilt is clamped to one row per column. Only row 1023 is black.
        '{ROW_CFG,   CFG_IMAGE_WIDTH,     1,    0,   1'b0, 0},
        '{ROW_FILL,  200,                 0,    0,   1'b0, 0},
        '{ROW_LOAD,  0,                   1023, 127, 1'b0, 0},
        '{ROW_LOAD,  0,                   512,  128, 1'b0, 0},
        '{ROW_SCORE, 0,                   0,    0,   1'b1, 1},
        '{ROW_SCORE, 1023,                0,    0,   1'b1, 1},
        '{ROW_SCORE, -1023,               0,    0,   1'b1, 1},
        // Zero height, then zero width with an oversized height.
        '{ROW_CFG,   CFG_IMAGE_HEIGHT,    0,    0,   1'b0, 0},
        '{ROW_SCORE, 5,                   0,    0,   1'b1, 0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,     0,    0,   1'b0, 0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT,    2047, 0,   1'b0, 0},
        '{ROW_SCORE, -5,                  0,    0,   1'b1, 0},
        // Oversized width saturates to the full 1024 columns of one row.
        '{ROW_CFG,   CFG_IMAGE_WIDTH,     2047, 0,   1'b0, 0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT,    1,    0,   1'b0, 0},
        '{ROW_FILL,  255,                 0,    0,   1'b0, 0},
        '{ROW_LOAD,  1023,                0,    0,   1'b0, 0},
        '{ROW_SCORE, 300,                 0,    0,   1'b1, 1},
        // A zero threshold makes even gray level 0 white.
        '{ROW_CFG,   CFG_BLACK_THRESHOLD, 0,    0,   1'b0, 0},
        '{ROW_LOAD,  1023,                0,    0,   1'b0, 0},
        '{ROW_SCORE, 1,                   0,    0,   1'b1, 0},
        // Small square, all black, then one white hole.
        '{ROW_CFG,   CFG_IMAGE_WIDTH,     8,    0,   1'b0, 0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT,    8,    0,   1'b0, 0},
        '{ROW_CFG,   CFG_BLACK_THRESHOLD, 255,  0,   1'b0, 0},
        '{ROW_FILL,  254,                 0,    0,   1'b0, 0},
        '{ROW_SCORE, -3,                  0,    0,   1'b1, 8},
        '{ROW_LOAD,  3,                   5,    255, 1'b0, 0},
        '{ROW_SCORE, 2,                   0,    0,   1'b0, 0},
        // All white, then a single black corner pixel seen at several tilts.
        '{ROW_CFG,   CFG_BLACK_THRESHOLD, 100,  0,   1'b0, 0},
        '{ROW_FILL,  200,                 0,    0,   1'b0, 0},
        '{ROW_SCORE, 0,                   0,    0,   1'b1, 0},
        '{ROW_LOAD,  7,                   7,    99,  1'b0, 0},
        '{ROW_SCORE, 0,                   0,    0,   1'b1, 1},
        '{ROW_SCORE, 3,                   0,    0,   1'b0, 0},
        '{ROW_SCORE, 1023,                0,    0,   1'b0, 0},
        '{ROW_SCORE, -1023,               0,    0,   1'b0, 0},
        '{ROW_LOAD,  1,                   1,    100, 1'b0, 0},
        '{ROW_SCORE, -1,                  0,    0,   1'b0, 0}
    };

    initial begin
        int rand_items;
        int rand_scores;
        int big_left;
        int run_len;
        int w, h, thr;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_LOAD;
        in_if.pixel_x    = '0;
        in_if.pixel_y    = '0;
        in_if.gray_level = '0;
        in_if.tilt       = '0;
        out_if.ready     = 1'b0;
        geom_w           = WIDTH_RESET;
        geom_h           = HEIGHT_RESET;
        thr_level        = THRESHOLD_RESET;
        mismatches       = 0;
        burst_left       = 0;
        sink_left        = 0;
        rand_items       = 0;
        rand_scores      = 0;
        big_left         = 3;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG:   write_reg(plan[i].a, plan[i].b);
                ROW_FILL:  fill_area(plan[i].a, 1'b1);
                ROW_LOAD:  send_word(FUNC_LOAD, plan[i].a, plan[i].b, plan[i].c,
                                     0, 1'b0, 0);
                default:   send_word(FUNC_SCORE, 0, 0, 0, plan[i].a,
                                     plan[i].has_count, plan[i].count);
            endcase
        end

        // Random phases: a new geometry and threshold, the unloaded part of
        // the image area filled in, then a run of loads and score requests.
        // A few phases use the largest sizes; most stay at eight or below.
        while (rand_items < 100 || rand_scores < 36) begin
            if (big_left > 0 && $urandom_range(0, 4) == 0) begin
                big_left--;
                case ($urandom_range(0, 2))
                    0: begin
                        w = $urandom_range(1024, 2047);
                        h = 1;
                    end
                    1: begin
                        w = 1;
                        h = $urandom_range(900, 1024);
                    end
                    default: begin
                        w = 1024;
                        h = 2;
                    end
                endcase
            end else begin
                w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
                h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
            end
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(1, 254);
            endcase
            write_reg(CFG_IMAGE_WIDTH, w);
            write_reg(CFG_IMAGE_HEIGHT, h);
            write_reg(CFG_BLACK_THRESHOLD, thr);
            fill_area(-1, 1'b0);
            if (w > MAX_WIDTH) begin
                w = MAX_WIDTH;
            end
            run_len = $urandom_range(6, 14);
            repeat (run_len) begin
                if ($urandom_range(0, 9) < 4) begin
                    send_word(FUNC_SCORE, 0, 0, 0, pick_tilt(), 1'b0, 0);
                    rand_scores++;
                end else if (w > 0 && h > 0 && $urandom_range(0, 9) < 7) begin
                    send_word(FUNC_LOAD, $urandom_range(0, w - 1),
                              $urandom_range(0, h - 1), pick_gray(), 0, 1'b0, 0);
                end else begin
                    // Loads outside the image area are kept in the map too.
                    send_word(FUNC_LOAD, $urandom_range(0, MAX_WIDTH - 1),
                              $urandom_range(0, MAX_HEIGHT - 1), pick_gray(),
                              0, 1'b0, 0);
                end
                rand_items++;
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
